/* rtl/hog_gradient_orientation_bin_defines.svh */
// assertion macros shared by the checker of the orientation binning block
`ifndef HOG_GRADIENT_ORIENTATION_BIN_DEFINES_SVH
`define HOG_GRADIENT_ORIENTATION_BIN_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define HGOB_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent a fixed number of cycles later
`define HGOB_DELAYED(lbl, ante, n, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error(msg);

`endif

/* rtl/hgob_pkg.sv */
// shared types, constants and tables of the orientation binning block
`timescale 1ns / 1ps
package hgob_pkg;

	localparam int MAX_BINS = 32;
	localparam int NB_W = $clog2(MAX_BINS) + 1;
	localparam int BIN_W = $clog2(MAX_BINS);
	localparam int CORDIC_STEPS = 20;
	localparam int ISQRT_STEPS = 17;

	// pipeline depths of each part
	localparam int LANE_STAGES = 3;
	localparam int MERGE_STAGES = 1;
	localparam int CORDIC_STAGES = CORDIC_STEPS + 1;
	localparam int BIN_STAGES = 4;
	localparam int LATENCY = LANE_STAGES + MERGE_STAGES + CORDIC_STAGES + BIN_STAGES;

	// register indexes of the configuration port
	typedef enum logic [1:0] {
		REG_BIN_COUNT   = 2'd0,
		REG_SIGNED_MODE = 2'd1,
		REG_GAMMA_ROOT  = 2'd2,
		REG_COLOR_MODE  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [NB_W-1:0] nb;
		logic            signed_mode;
		logic            gamma_root;
		logic            color_mode;
	} cfg_t;

	typedef logic signed [16:0] diff_t;
	typedef logic [32:0]        msq_t;

	typedef struct packed {
		diff_t dx;
		diff_t dy;
		msq_t  msq;
	} grad_t;

	// atan(2^-i) as a fraction of a full turn, units of 2^-32
	localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518
	};

	typedef logic [11:0] sqrt_lut_t [256];

	// floor(sqrt(s) * 256) for every sample value
	function automatic sqrt_lut_t build_sqrt_lut();
		sqrt_lut_t lut;
		longint    v;
		longint    r;
		longint    t;
		for (int s = 0; s < 256; s++) begin
			v = longint'(s) << 16;
			r = 0;
			for (int b = 11; b >= 0; b--) begin
				t = r | (longint'(1) << b);
				if (t * t <= v) begin
					r = t;
				end
			end
			lut[s] = r[11:0];
		end
		return lut;
	endfunction

	localparam sqrt_lut_t SQRT_LUT = build_sqrt_lut();

endpackage

/* rtl/hgob_lane.sv */
// one channel lane: level map, central differences and squared magnitude
`timescale 1ns / 1ps
module hgob_lane (
	input  logic            clk,
	input  logic            gamma_root,
	input  logic [7:0]      s_left,
	input  logic [7:0]      s_right,
	input  logic [7:0]      s_above,
	input  logic [7:0]      s_below,
	output hgob_pkg::grad_t grad
);
	import hgob_pkg::*;

	diff_t              dx_c, dy_c;
	diff_t              dx_s1, dy_s1, dx_s2, dy_s2;
	logic signed [33:0] px_c, py_c;
	logic [31:0]        sqx_s2, sqy_s2;
	grad_t              grad_s3;

	function automatic logic [15:0] level(input logic [7:0] s, input logic g);
		return g ? {4'd0, SQRT_LUT[s]} : {s, 8'd0};
	endfunction

	// central differences
	always_comb begin
		dx_c = $signed({1'b0, level(s_right, gamma_root)})
			- $signed({1'b0, level(s_left, gamma_root)});
		dy_c = $signed({1'b0, level(s_below, gamma_root)})
			- $signed({1'b0, level(s_above, gamma_root)});
	end

	// squares
	always_comb begin
		px_c = dx_s1 * dx_s1;
		py_c = dy_s1 * dy_s1;
	end

	always_ff @(posedge clk) begin
		dx_s1 <= dx_c;
		dy_s1 <= dy_c;
		dx_s2 <= dx_s1;
		dy_s2 <= dy_s1;
		sqx_s2 <= px_c[31:0];
		sqy_s2 <= py_c[31:0];
		grad_s3.dx <= dx_s2;
		grad_s3.dy <= dy_s2;
		grad_s3.msq <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
	end

	assign grad = grad_s3;

endmodule

/* rtl/hgob_merge.sv */
// in color mode keeps the lane of largest squared magnitude, channel 2 on ties
`timescale 1ns / 1ps
module hgob_merge (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            color_mode,
	input  logic            in_valid,
	input  hgob_pkg::grad_t lane0,
	input  hgob_pkg::grad_t lane1,
	input  hgob_pkg::grad_t lane2,
	output logic            out_valid,
	output hgob_pkg::grad_t best
);
	import hgob_pkg::*;

	grad_t sel_c;
	grad_t best_s1;
	logic  valid_s1;

	// color mode off keeps lane 0; strict compares favour 2, then 1, on ties
	always_comb begin
		sel_c = color_mode ? lane2 : lane0;
		if (color_mode) begin
			if (lane1.msq > sel_c.msq) begin
				sel_c = lane1;
			end
			if (lane0.msq > sel_c.msq) begin
				sel_c = lane0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		best_s1 <= sel_c;
	end

	assign out_valid = valid_s1;
	assign best = best_s1;

endmodule

/* rtl/hgob_cordic.sv */
// pipelined cordic angle and integer square root of the kept gradient
`timescale 1ns / 1ps
module hgob_cordic (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  hgob_pkg::grad_t grad,
	output logic            out_valid,
	output logic [31:0]     angle,
	output logic [15:0]     mag
);
	import hgob_pkg::*;

	logic signed [35:0] x_s    [CORDIC_STAGES];
	logic signed [35:0] y_s    [CORDIC_STAGES];
	logic [31:0]        z_s    [CORDIC_STAGES];
	logic [35:0]        rem_s  [CORDIC_STAGES];
	logic [35:0]        root_s [CORDIC_STAGES];
	logic               v_s    [CORDIC_STAGES];

	logic signed [35:0] ax_c, ay_c;
	logic               neg_c;

	// fold into the right half plane and prescale
	always_comb begin
		neg_c = grad.dx[16];
		ax_c = 36'(grad.dx);
		ay_c = 36'(grad.dy);
		if (neg_c) begin
			ax_c = -ax_c;
			ay_c = -ay_c;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0] <= ax_c <<< 14;
		y_s[0] <= ay_c <<< 14;
		z_s[0] <= neg_c ? 32'h80000000 : 32'h0;
		rem_s[0] <= 36'(grad.msq);
		root_s[0] <= '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [35:0] xs, ys, nx, ny;
		logic [31:0]        nz;
		logic [35:0]        nrem, nroot;

		// one rotation, stopped once the residual is zero
		always_comb begin
			xs = x_s[i] >>> i;
			ys = y_s[i] >>> i;
			nx = x_s[i];
			ny = y_s[i];
			nz = z_s[i];
			if (y_s[i] != '0) begin
				if (!y_s[i][35]) begin
					nx = x_s[i] + ys;
					ny = y_s[i] - xs;
					nz = z_s[i] + ATAN_TURN[i];
				end else begin
					nx = x_s[i] - ys;
					ny = y_s[i] + xs;
					nz = z_s[i] - ATAN_TURN[i];
				end
			end
		end

		// one digit of the square root
		if (i < ISQRT_STEPS) begin : g_root
			localparam logic [35:0] BIT = 36'(1) << (32 - 2 * i);
			logic [35:0] trial;
			always_comb begin
				trial = root_s[i] + BIT;
				if (rem_s[i] >= trial) begin
					nrem = rem_s[i] - trial;
					nroot = (root_s[i] >> 1) + BIT;
				end else begin
					nrem = rem_s[i];
					nroot = root_s[i] >> 1;
				end
			end
		end else begin : g_pass
			always_comb begin
				nrem = rem_s[i];
				nroot = root_s[i];
			end
		end

		always_ff @(posedge clk) begin
			x_s[i+1] <= nx;
			y_s[i+1] <= ny;
			z_s[i+1] <= nz;
			rem_s[i+1] <= nrem;
			root_s[i+1] <= nroot;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end
	end

	assign out_valid = v_s[CORDIC_STEPS];
	assign angle = z_s[CORDIC_STEPS];
	assign mag = root_s[CORDIC_STEPS][16:1];

endmodule

/* rtl/hgob_bin.sv */
// bin position from the angle and split of the magnitude between two bins
`timescale 1ns / 1ps
module hgob_bin (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hgob_pkg::cfg_t         cfg,
	input  logic                   in_valid,
	input  logic [31:0]            angle,
	input  logic [15:0]            mag,
	output logic                   out_valid,
	output logic [15:0]            weight_first,
	output logic [15:0]            weight_second,
	output logic [hgob_pkg::BIN_W-1:0] bin_first,
	output logic [hgob_pkg::BIN_W-1:0] bin_second
);
	import hgob_pkg::*;

	localparam int POS_W = BIN_W + 8;
	localparam int SPAN_W = NB_W + 8;

	logic [NB_W:0]         k_c;
	logic [NB_W+32:0]      prod_c;
	logic [NB_W+8:0]       p_s1;
	logic [15:0]           m7_s1, m7_s2, m7_s3;
	logic signed [SPAN_W+1:0] t_c, pos_c, span_c;
	logic [POS_W-1:0]      pos_s2;
	logic [NB_W-1:0]       nxt_c;
	logic [23:0]           wp_c;
	logic [BIN_W-1:0]      hidx_s3, second_s3, hidx_s4, second_s4;
	logic [15:0]           w2_s3, w1_s4, w2_s4;
	logic                  v_s1, v_s2, v_s3, v_s4;

	// angle times bins per turn
	always_comb begin
		k_c = cfg.signed_mode ? {1'b0, cfg.nb} : {cfg.nb, 1'b0};
		prod_c = (NB_W + 33)'(angle) * (NB_W + 33)'(k_c);
	end

	// half bin shift and wrap into one span
	always_comb begin
		span_c = (SPAN_W + 2)'({cfg.nb, 8'd0});
		t_c = $signed({1'b0, p_s1}) - (SPAN_W + 2)'(128);
		if (t_c < 0) begin
			pos_c = t_c + span_c;
		end else if (t_c >= span_c) begin
			pos_c = t_c - span_c;
		end else begin
			pos_c = t_c;
		end
	end

	// neighbour bin and magnitude split
	always_comb begin
		nxt_c = NB_W'(pos_s2[POS_W-1:8]) + NB_W'(1);
		wp_c = m7_s2 * pos_s2[7:0];
	end

	always_ff @(posedge clk) begin
		p_s1 <= prod_c[NB_W+32:24];
		m7_s1 <= mag;
		pos_s2 <= pos_c[POS_W-1:0];
		m7_s2 <= m7_s1;
		hidx_s3 <= pos_s2[POS_W-1:8];
		second_s3 <= (nxt_c >= cfg.nb) ? '0 : nxt_c[BIN_W-1:0];
		w2_s3 <= wp_c[23:8];
		m7_s3 <= m7_s2;
		hidx_s4 <= hidx_s3;
		second_s4 <= second_s3;
		w1_s4 <= m7_s3 - w2_s3;
		w2_s4 <= w2_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign out_valid = v_s4;
	assign weight_first = w1_s4;
	assign weight_second = w2_s4;
	assign bin_first = hidx_s4;
	assign bin_second = second_s4;

endmodule

/* rtl/hog_gradient_orientation_bin.sv */
// top level of the gradient orientation binning block
// channel   | direction | handshake            | content
// request   | in        | start, busy          | four neighbour samples of three channels
// result    | out       | done (one cycle)     | two bin indices and two weights
// config    | in        | cfg_valid, cfg_ready | register index and data
// one pixel is taken every cycle while busy is low; each result is registered through the
// three lane stages, the merge, the 21 cordic and square-root stages and the four binning
// stages. busy is high only in reset and the cycle after it.
// the result side cannot stall; config writes are taken at any time, cfg_ready stays high.
`timescale 1ns / 1ps
module hog_gradient_orientation_bin (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [7:0]             ch0_left,
	input  logic [7:0]             ch0_right,
	input  logic [7:0]             ch0_above,
	input  logic [7:0]             ch0_below,
	input  logic [7:0]             ch1_left,
	input  logic [7:0]             ch1_right,
	input  logic [7:0]             ch1_above,
	input  logic [7:0]             ch1_below,
	input  logic [7:0]             ch2_left,
	input  logic [7:0]             ch2_right,
	input  logic [7:0]             ch2_above,
	input  logic [7:0]             ch2_below,
	output logic                   done,
	output logic [15:0]            weight_first,
	output logic [15:0]            weight_second,
	output logic [4:0]             bin_first,
	output logic [4:0]             bin_second,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [5:0]             cfg_data
);
	import hgob_pkg::*;

	logic [5:0]      bin_count_q;
	logic            signed_mode_q, gamma_root_q, color_mode_q, ready_q;
	logic            v_s1, v_s2, v_s3;
	logic            merge_valid, cordic_valid;
	cfg_t            cfg;
	grad_t           lane0, lane1, lane2, best;
	logic [31:0]     angle;
	logic [15:0]     mag;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_count_q <= 6'd9;
			signed_mode_q <= 1'b0;
			gamma_root_q <= 1'b0;
			color_mode_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_BIN_COUNT: bin_count_q <= cfg_data;
				REG_SIGNED_MODE: signed_mode_q <= cfg_data[0];
				REG_GAMMA_ROOT: gamma_root_q <= cfg_data[0];
				REG_COLOR_MODE: color_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// bin count clamped to its usable range
	always_comb begin
		if (bin_count_q == '0) begin
			cfg.nb = NB_W'(1);
		end else if (bin_count_q > NB_W'(MAX_BINS)) begin
			cfg.nb = NB_W'(MAX_BINS);
		end else begin
			cfg.nb = bin_count_q;
		end
		cfg.signed_mode = signed_mode_q;
		cfg.gamma_root = gamma_root_q;
		cfg.color_mode = color_mode_q;
	end

	// request valid through the lane stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			ready_q <= 1'b1;
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign busy = !ready_q;
	assign cfg_ready = 1'b1;

	hgob_lane u_lane0 (
		.clk(clk), .gamma_root(gamma_root_q),
		.s_left(ch0_left), .s_right(ch0_right), .s_above(ch0_above), .s_below(ch0_below),
		.grad(lane0)
	);

	hgob_lane u_lane1 (
		.clk(clk), .gamma_root(gamma_root_q),
		.s_left(ch1_left), .s_right(ch1_right), .s_above(ch1_above), .s_below(ch1_below),
		.grad(lane1)
	);

	hgob_lane u_lane2 (
		.clk(clk), .gamma_root(gamma_root_q),
		.s_left(ch2_left), .s_right(ch2_right), .s_above(ch2_above), .s_below(ch2_below),
		.grad(lane2)
	);

	hgob_merge u_merge (
		.clk(clk), .arst_n(arst_n), .color_mode(color_mode_q), .in_valid(v_s3),
		.lane0(lane0), .lane1(lane1), .lane2(lane2),
		.out_valid(merge_valid), .best(best)
	);

	hgob_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .in_valid(merge_valid), .grad(best),
		.out_valid(cordic_valid), .angle(angle), .mag(mag)
	);

	hgob_bin u_bin (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .in_valid(cordic_valid),
		.angle(angle), .mag(mag), .out_valid(done),
		.weight_first(weight_first), .weight_second(weight_second),
		.bin_first(bin_first), .bin_second(bin_second)
	);

endmodule

/* rtl/hgob_checker.sv */
// port level checks of the orientation binning block and their binding
`timescale 1ns / 1ps
`include "hog_gradient_orientation_bin_defines.svh"
module hgob_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [15:0] weight_first,
	input logic [15:0] weight_second,
	input logic [4:0]  bin_first,
	input logic [4:0]  bin_second,
	input logic        cfg_valid,
	input logic        cfg_ready
);
	import hgob_pkg::*;

	logic        pair_ok_c;
	logic [16:0] wsum_c;

	// bin pair relation and weight total
	assign pair_ok_c = (bin_second == bin_first + 5'd1) || (bin_second == 5'd0);
	assign wsum_c = {1'b0, weight_first} + {1'b0, weight_second};

	// every request gives one result after the fixed latency
	`HGOB_DELAYED(a_req_to_done, start && !busy, LATENCY, done, "request without result")
	// no result without a request the fixed latency before
	`HGOB_IMPLIES(a_done_has_req, done, $past(start && !busy, LATENCY), "result without request")
	// second bin follows the first or wraps to zero
	`HGOB_IMPLIES(a_bin_pair, done, pair_ok_c, "bin pair broken")
	// the two weights never exceed the largest magnitude
	`HGOB_IMPLIES(a_weight_sum, done, wsum_c <= 17'd46208, "weight sum too large")
	// config writes are never refused
	`HGOB_IMPLIES(a_cfg_ready, cfg_valid, cfg_ready, "config write refused")

endmodule

bind hog_gradient_orientation_bin hgob_checker u_hgob_checker (.*);
